// File: hw/rtl/mpb_pkg.sv
// ============================================================================
// mpb_pkg - shared types and constants for the masked pixel binning block
// Field widths, configuration register indexes, divider sizing and the
// code that marks a bad block.
// ============================================================================
`default_nettype none

package mpb_pkg;

    // Defaults for the top level parameters
    localparam int MAX_OUT_COLUMNS_DEF = 4096;
    localparam int MAX_BIN_DEF         = 8;

    // Item field widths
    localparam int SAMPLE_W = 32;
    localparam int MAX_W    = 31;

    // Panel geometry
    localparam int PANEL_LIMIT = 4096;
    localparam int POS_W       = 12;
    localparam int DIM_W       = 13;

    // Configuration port
    localparam int BF_W      = 4;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd2;

    localparam logic [BF_W-1:0]  BF_RESET = 4'd1;
    localparam logic [DIM_W-1:0] PW_RESET = 13'd1024;
    localparam logic [DIM_W-1:0] PH_RESET = 13'd1024;

    // Iterative divider: quotient bits, bits per cycle, cycles
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Value given for a block that holds a bad pixel (most negative 32-bit value)
    localparam logic [SAMPLE_W-1:0] BAD_VALUE = 32'h8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/mpb_in_if.sv
// ============================================================================
// mpb_in_if - pixel input channel
// Valid/ready channel that carries one pixel sample and its bad flag.
// ============================================================================
`default_nettype none

interface mpb_in_if;
    import mpb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       pixel_bad;

    modport source (output valid, output sample, output pixel_bad, input ready);
    modport sink   (input valid, input sample, input pixel_bad, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mpb_out_if.sv
// ============================================================================
// mpb_out_if - binned pixel output channel
// Valid/ready channel that carries one block average with its flags.
// ============================================================================
`default_nettype none

interface mpb_out_if;
    import mpb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] binned_value;
    logic                       binned_bad;
    logic        [MAX_W-1:0]    panel_max;
    logic                       end_of_row;
    logic                       last_of_panel;

    modport source (
        output valid, output binned_value, output binned_bad, output panel_max,
        output end_of_row, output last_of_panel, input ready
    );
    modport sink (
        input valid, input binned_value, input binned_bad, input panel_max,
        input end_of_row, input last_of_panel, output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/masked_pixel_binning.sv
// ============================================================================
// masked_pixel_binning - square block averaging of a masked detector panel
// Sums bin x bin pixel blocks through a per-column memory, divides by the
// block area and tracks the panel maximum of good averages.
// ============================================================================
// Pixels enter in raster order, columns first. A pixel outside the area
// covered by whole blocks is taken without a memory access. For a pixel
// inside it, the column sum memory is read in the accept cycle and the
// updated sum written back in the next, and the next pixel is taken after
// that. The pixel that closes a block then runs the iterative divider, four
// quotient bits per cycle, and then loads the output register, after any
// wait while the previous result is still held at the output. Input is
// taken while a result waits in the output register. The column memory has
// no reset; an entry is always rewritten in the first row of its block
// before its read value is used.
// ============================================================================
`default_nettype none

module masked_pixel_binning #(
    parameter int MAX_OUT_COLUMNS = mpb_pkg::MAX_OUT_COLUMNS_DEF,
    parameter int MAX_BIN         = mpb_pkg::MAX_BIN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mpb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mpb_pkg::CFG_W-1:0]     i_cfg_data,
    mpb_in_if.sink                             i_pix,
    mpb_out_if.source                          o_bin
);
    import mpb_pkg::*;

    localparam int BIN_W  = $clog2(MAX_BIN + 1);
    localparam int DIV_W  = $clog2(MAX_BIN * MAX_BIN + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_BIN * MAX_BIN);
    localparam int MEM_W  = SUM_W + 1;
    localparam int COL_AW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
    localparam int EXT_W  = DIM_W + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RMW  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Configuration registers
    logic [BF_W-1:0]  r_bf;
    logic [DIM_W-1:0] r_pw;
    logic [DIM_W-1:0] r_ph;

    // Control state
    t_state           r_state;
    logic [POS_W-1:0] r_col, r_row, r_oc;
    logic [BIN_W-1:0] r_cphase, r_rphase;
    logic [MAX_W-1:0] r_max;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic             r_ov;

    // Item held across the read-modify-write
    logic signed [SAMPLE_W-1:0] r_sample;
    logic              r_pbad, r_first, r_res, r_eor, r_lop, r_eop;
    logic [COL_AW-1:0] r_addr;

    // Divider and block result
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_dvd;
    logic             r_neg, r_bbad;

    // Output register payload
    logic signed [SAMPLE_W-1:0] r_oval;
    logic             r_obad, r_oeor, r_olop;
    logic [MAX_W-1:0] r_omax;

    // Column memory: {bad, sum}
    logic [MEM_W-1:0] mem [MAX_OUT_COLUMNS];
    logic [MEM_W-1:0] r_rd;

    // Clamp the configuration
    logic [BIN_W-1:0] bin;
    logic [DIM_W-1:0] wid, hgt;
    logic [DIV_W-1:0] dsr;
    logic [2*BIN_W-1:0] bsq;

    always_comb begin
        if (r_bf == '0) begin
            bin = BIN_W'(1);
        end else if (32'(r_bf) > MAX_BIN) begin
            bin = BIN_W'(MAX_BIN);
        end else begin
            bin = BIN_W'(r_bf);
        end
        if (r_pw == '0) begin
            wid = DIM_W'(1);
        end else if (32'(r_pw) > PANEL_LIMIT) begin
            wid = DIM_W'(PANEL_LIMIT);
        end else begin
            wid = r_pw;
        end
        if (r_ph == '0) begin
            hgt = DIM_W'(1);
        end else if (32'(r_ph) > PANEL_LIMIT) begin
            hgt = DIM_W'(PANEL_LIMIT);
        end else begin
            hgt = r_ph;
        end
    end

    assign bsq = {{BIN_W{1'b0}}, bin} * {{BIN_W{1'b0}}, bin};
    assign dsr = DIV_W'(bsq);

    // Decode the position of the incoming pixel
    logic [POS_W-1:0] col_start, row_start;
    logic col_fit, row_fit, oc_ok, active, first, res, eor, lop;
    logic cwrap, rwrap, col_end, row_end, eop;
    logic [POS_W-1:0] n_col, n_row, n_oc;
    logic [BIN_W-1:0] n_cphase, n_rphase;

    always_comb begin
        col_start = r_col - POS_W'(r_cphase);
        row_start = r_row - POS_W'(r_rphase);
        col_fit = (EXT_W'(col_start) + EXT_W'(bin)) <= EXT_W'(wid);
        row_fit = (EXT_W'(row_start) + EXT_W'(bin)) <= EXT_W'(hgt);
        oc_ok   = 32'(r_oc) < MAX_OUT_COLUMNS;
        active  = col_fit && row_fit && oc_ok;
        first   = (r_cphase == '0) && (r_rphase == '0);
        cwrap   = ((BIN_W+1)'(r_cphase) + (BIN_W+1)'(1)) >= (BIN_W+1)'(bin);
        rwrap   = ((BIN_W+1)'(r_rphase) + (BIN_W+1)'(1)) >= (BIN_W+1)'(bin);
        res     = cwrap && rwrap;
        eor     = (EXT_W'(col_start) + (EXT_W'(bin) << 1)) > EXT_W'(wid);
        lop     = eor && ((EXT_W'(row_start) + (EXT_W'(bin) << 1)) > EXT_W'(hgt));
        col_end = (DIM_W'(r_col) + DIM_W'(1)) >= wid;
        row_end = (DIM_W'(r_row) + DIM_W'(1)) >= hgt;
        eop     = col_end && row_end;

        n_col    = r_col + POS_W'(1);
        n_row    = r_row;
        n_oc     = cwrap ? r_oc + POS_W'(1) : r_oc;
        n_cphase = cwrap ? '0 : r_cphase + BIN_W'(1);
        n_rphase = r_rphase;
        if (col_end) begin
            n_col    = '0;
            n_oc     = '0;
            n_cphase = '0;
            if (row_end) begin
                n_row    = '0;
                n_rphase = '0;
            end else begin
                n_row    = r_row + POS_W'(1);
                n_rphase = rwrap ? '0 : r_rphase + BIN_W'(1);
            end
        end
    end

    // Handshake terms
    logic in_acc, out_take, out_load, mem_re, mem_we;

    assign i_pix.ready = (r_state == S_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign out_take    = r_ov && o_bin.ready;
    assign out_load    = (r_state == S_DONE) && (!r_ov || o_bin.ready);
    assign mem_re      = in_acc && active;
    assign mem_we      = (r_state == S_RMW);

    // Update the column sum
    logic signed [SUM_W-1:0] rd_sum, n_sum;
    logic             n_bad;
    logic [SUM_W-1:0] mag;

    always_comb begin
        rd_sum = r_rd[SUM_W-1:0];
        if (r_first) begin
            n_sum = SUM_W'(r_sample);
            n_bad = r_pbad;
        end else begin
            n_sum = rd_sum + SUM_W'(r_sample);
            n_bad = r_rd[SUM_W] | r_pbad;
        end
        mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    // Column memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= {n_bad, n_sum};
        end
        if (mem_re) begin
            r_rd <= mem[COL_AW'(r_oc)];
        end
    end

    // Divider step: several restoring steps per cycle
    logic [DIV_W-1:0] n_rem;
    logic [QUO_W-1:0] n_dvd;

    always_comb begin
        logic [DIV_W:0] t;
        logic           qb;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {n_rem, n_dvd[QUO_W-1]};
            if (t >= {1'b0, dsr}) begin
                t  = t - {1'b0, dsr};
                qb = 1'b1;
            end else begin
                qb = 1'b0;
            end
            n_rem = t[DIV_W-1:0];
            n_dvd = {n_dvd[QUO_W-2:0], qb};
        end
    end

    // Form the block result and the new maximum
    logic signed [SAMPLE_W-1:0] avg, n_oval;
    logic [MAX_W-1:0] n_max;

    always_comb begin
        avg   = r_neg ? -$signed(r_dvd) : $signed(r_dvd);
        n_max = r_max;
        if (r_bbad) begin
            n_oval = BAD_VALUE;
        end else begin
            n_oval = avg;
            if (!r_neg && (r_dvd > {1'b0, r_max})) begin
                n_max = r_dvd[MAX_W-1:0];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bf <= BF_RESET;
            r_pw <= PW_RESET;
            r_ph <= PH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIN_FACTOR:   r_bf <= i_cfg_data[BF_W-1:0];
                CFG_PANEL_WIDTH:  r_pw <= i_cfg_data;
                CFG_PANEL_HEIGHT: r_ph <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, positions and maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_oc     <= '0;
            r_cphase <= '0;
            r_rphase <= '0;
            r_max    <= '0;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col    <= n_col;
                        r_row    <= n_row;
                        r_oc     <= n_oc;
                        r_cphase <= n_cphase;
                        r_rphase <= n_rphase;
                        if (active) begin
                            r_state <= S_RMW;
                        end else if (eop) begin
                            r_max <= '0;
                        end
                    end
                end
                S_RMW: begin
                    if (r_res) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_state <= S_IDLE;
                        if (r_eop) begin
                            r_max <= '0;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                        r_max   <= r_eop ? '0 : n_max;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold the accepted item and run the divider
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_pix.sample;
            r_pbad   <= i_pix.pixel_bad;
            r_first  <= first;
            r_res    <= res;
            r_eor    <= eor;
            r_lop    <= lop;
            r_eop    <= eop;
            r_addr   <= COL_AW'(r_oc);
        end
        if (r_state == S_RMW) begin
            r_rem  <= DIV_W'(mag >> QUO_W);
            r_dvd  <= mag[QUO_W-1:0];
            r_neg  <= n_sum[SUM_W-1];
            r_bbad <= n_bad;
        end else if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oval <= n_oval;
            r_obad <= r_bbad;
            r_omax <= n_max;
            r_oeor <= r_eor;
            r_olop <= r_lop;
        end
    end

    assign o_bin.valid         = r_ov;
    assign o_bin.binned_value  = r_oval;
    assign o_bin.binned_bad    = r_obad;
    assign o_bin.panel_max     = r_omax;
    assign o_bin.end_of_row    = r_oeor;
    assign o_bin.last_of_panel = r_olop;

endmodule

`default_nettype wire
